>>> hdl/stifs_pkg.sv
// Shared types and constants for the sparse time index floor search block.
`default_nettype none
package stifs_pkg;

    localparam int unsigned INDEX_DEPTH_DEF = 1024;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned CNT_W           = 6;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned COUNT_REG_W     = 11;
    localparam int unsigned SLOT_W          = 10;
    localparam int unsigned KIND_W          = 3;

    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BEFORE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AFTER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLOOR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd5;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OLDEST_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEWEST_TIME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OLDEST_RECORD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEWEST_RECORD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECORDS_IN_BLOCK = 3'd5;

    typedef struct packed {
        logic                  req_type;
        logic [SLOT_W-1:0]     entry_slot;
        logic [DATA_W-1:0]     entry_time;
        logic [DATA_W-1:0]     entry_block;
        logic [DATA_W-1:0]     query_time;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0]     blk_num;
        logic [KIND_W-1:0]     found_kind;
    } t_out;

    typedef struct packed {
        logic [DATA_W-1:0]     stamp;
        logic [DATA_W-1:0]     blk;
    } t_entry;

    typedef struct packed {
        logic                  start;
        logic [DATA_W-1:0]     dividend;
        logic [DATA_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DATA_W-1:0]     quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> hdl/stifs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module stifs_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire stifs_pkg::t_div_req i_req,
    output stifs_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned DW = stifs_pkg::DATA_W;
    localparam int unsigned CW = stifs_pkg::CNT_W;

    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;

    // a zero divisor never borrows, so the quotient comes out all ones
    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_div};
        if (!w_diff[DW]) begin
            n_rem = w_diff[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = w_shift[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not take start");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done && !r_busy)
        else $error("divider done longer than one cycle");

endmodule
`default_nettype wire

>>> hdl/sparse_time_index_floor_search.sv
// Top level: index table memory, lookup sequencer and output register.
// Usage:
//   Input channel i_in (valid/ready) carries write and lookup requests.
//   A write stores {entry_time, entry_block} in the table and gives no result;
//   writes are taken one per cycle while the sequencer is idle. A lookup
//   gives one beat on o_out. Lookup sequence from the accepting edge: a
//   classify state, then either a search of up to ceil(log2(entry_count+1))
//   table reads (11 for 1024 entries), one read per cycle from the single
//   table read port, or a wait on the divider for the before-oldest and
//   after-newest cases, or nothing for an empty table, then a result state.
//   The beat becomes valid in the same cycle that i_in is ready again. One
//   lookup is in work at a time; i_in is ready only when the sequencer is
//   idle.
//   The output register holds a finished beat while the receiver stalls; the
//   next item is still taken meanwhile, and a new result waits until the
//   register is free.
//   Reset clears control state and sets the configuration registers to their
//   reset values. The table is not cleared: entries read before being written
//   give undefined results. The user must write configuration through
//   i_cfg_we/i_cfg_index/i_cfg_data only while the block is idle (not enforced).
`default_nettype none
module sparse_time_index_floor_search #(
    parameter int unsigned INDEX_DEPTH = stifs_pkg::INDEX_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire stifs_pkg::t_in                      i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output stifs_pkg::t_out                          o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [stifs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [stifs_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned DW  = stifs_pkg::DATA_W;
    localparam int unsigned AW  = $clog2(INDEX_DEPTH);
    localparam int unsigned CW  = $clog2(INDEX_DEPTH + 1);
    localparam int unsigned XW  = 17;
    localparam int unsigned ECW = stifs_pkg::COUNT_REG_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLASS  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    // configuration
    logic [ECW-1:0] r_entry_count;
    logic [DW-1:0]  r_oldest_time, r_newest_time;
    logic [DW-1:0]  r_oldest_record, r_newest_record;
    logic [DW-1:0]  r_records_in_block;

    // sequencer
    logic [2:0]     r_state, n_state;
    logic [DW-1:0]  r_query;
    logic [CW-1:0]  r_lo, n_lo;
    logic [CW-1:0]  r_hi1, n_hi1;
    logic [AW-1:0]  r_mid, n_mid;
    logic [DW-1:0]  r_best, n_best;
    logic           r_have_best, n_have_best;
    stifs_pkg::t_out r_res, n_res;

    // output register
    logic            r_out_valid;
    stifs_pkg::t_out r_out;

    // table
    stifs_pkg::t_entry r_mem [INDEX_DEPTH];
    stifs_pkg::t_entry r_rd_data;
    logic              w_mem_we;
    logic [AW-1:0]     w_wr_addr;
    logic              w_mem_re;
    logic [XW-1:0]     w_slot_ext;
    logic [XW-1:0]     w_count_ext;
    logic [CW-1:0]     w_count;
    logic              w_accept;
    logic              w_out_free;

    stifs_pkg::t_div_req w_div_req;
    stifs_pkg::t_div_rsp w_div_rsp;

    function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi1);
        logic [CW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi1} - (CW+1)'(1);
        return sum[AW:1];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_slot_ext  = XW'(i_in.entry_slot);
    assign w_wr_addr   = w_slot_ext[AW-1:0];
    assign w_mem_we    = w_accept && (i_in.req_type == stifs_pkg::REQ_WRITE) &&
                         (w_slot_ext < XW'(INDEX_DEPTH));

    assign w_count_ext = (XW'(r_entry_count) > XW'(INDEX_DEPTH)) ?
                         XW'(INDEX_DEPTH) : XW'(r_entry_count);
    assign w_count     = w_count_ext[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count      <= '0;
            r_oldest_time      <= '0;
            r_newest_time      <= '0;
            r_oldest_record    <= '0;
            r_newest_record    <= '0;
            r_records_in_block <= DW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stifs_pkg::REG_ENTRY_COUNT:      r_entry_count      <= i_cfg_data[ECW-1:0];
                stifs_pkg::REG_OLDEST_TIME:      r_oldest_time      <= i_cfg_data;
                stifs_pkg::REG_NEWEST_TIME:      r_newest_time      <= i_cfg_data;
                stifs_pkg::REG_OLDEST_RECORD:    r_oldest_record    <= i_cfg_data;
                stifs_pkg::REG_NEWEST_RECORD:    r_newest_record    <= i_cfg_data;
                stifs_pkg::REG_RECORDS_IN_BLOCK: r_records_in_block <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi1        = r_hi1;
        n_mid        = r_mid;
        n_best       = r_best;
        n_have_best  = r_have_best;
        n_res        = r_res;
        w_mem_re     = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_oldest_record;
        w_div_req.divisor  = r_records_in_block;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in.req_type == stifs_pkg::REQ_LOOKUP) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_have_best = 1'b0;
                n_best      = '0;
                if (w_count == '0) begin
                    n_res.blk_num    = '0;
                    n_res.found_kind = stifs_pkg::KIND_EMPTY;
                    n_state          = S_RESULT;
                end else if (r_query < r_oldest_time) begin
                    w_div_req.start  = 1'b1;
                    n_res.found_kind = stifs_pkg::KIND_BEFORE;
                    n_state          = S_DIV;
                end else if (r_query > r_newest_time) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_newest_record;
                    n_res.found_kind   = stifs_pkg::KIND_AFTER;
                    n_state            = S_DIV;
                end else begin
                    n_lo     = '0;
                    n_hi1    = w_count;
                    n_mid    = mid_of('0, w_count);
                    w_mem_re = 1'b1;
                    n_state  = S_SEARCH;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res.blk_num = w_div_rsp.quotient;
                    n_state       = S_RESULT;
                end
            end
            S_SEARCH: begin
                // zero stamp marks an unused slot and steers left
                if (r_rd_data.stamp == '0) begin
                    n_hi1 = CW'(r_mid);
                end else if (r_rd_data.stamp == r_query) begin
                    n_res.blk_num    = r_rd_data.blk;
                    n_res.found_kind = stifs_pkg::KIND_EXACT;
                    n_state          = S_RESULT;
                end else if (r_rd_data.stamp < r_query) begin
                    n_best      = r_rd_data.blk;
                    n_have_best = 1'b1;
                    n_lo        = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi1 = CW'(r_mid);
                end
                if (n_state == S_SEARCH) begin
                    if (n_lo < n_hi1) begin
                        n_mid    = mid_of(n_lo, n_hi1);
                        w_mem_re = 1'b1;
                    end else begin
                        n_res.blk_num    = n_have_best ? n_best : '0;
                        n_res.found_kind = n_have_best ? stifs_pkg::KIND_FLOOR :
                                                         stifs_pkg::KIND_NONE;
                        n_state          = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= i_in.query_time;
        end
        r_lo        <= n_lo;
        r_hi1       <= n_hi1;
        r_mid       <= n_mid;
        r_best      <= n_best;
        r_have_best <= n_have_best;
        r_res       <= n_res;
        if (r_state == S_RESULT && w_out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= {i_in.entry_time, i_in.entry_block};
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[n_mid];
        end
    end

    stifs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo < r_hi1))
        else $error("search running on an empty range");

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CW'(r_mid) >= r_lo && CW'(r_mid) < r_hi1))
        else $error("probe outside the search range");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("division finished outside its wait state");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_out_valid && !i_out_ready) |=> (r_state == S_RESULT))
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire
